// ----- hw/rtl/vrp_pkg.sv -----
// Shared types, widths and constants for the 4D vertex rotate/project block.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package vrp_pkg;

    // Field widths
    localparam int COORD_W   = 16;
    localparam int ANG_W     = 16;
    localparam int SIN_W     = 16;
    localparam int OUT_W     = 12;
    localparam int REG_IDX_W = 3;

    // Datapath widths
    localparam int VW    = 28;          // working coordinate
    localparam int S4_W  = 20;          // 4D scale, signed Q12
    localparam int S3_W  = 16;          // 3D scale, unsigned Q12
    localparam int ACC_W = 52;          // accumulator
    localparam int DVD_W = 28;          // divider dividend / quotient
    localparam int DVS_W = VW + 1;      // divider divisor

    // Arithmetic constants
    localparam int QUARTER    = 16384;
    localparam int ROT_RND    = 8192;
    localparam int PRJ_RND    = 2048;
    localparam int S4_LIMIT   = 524287;
    localparam int DEN_FLOOR  = 410;
    localparam int SCALE_MIN  = 410;
    localparam int SCALE_MAX  = 20480;
    localparam int PIXEL_GAIN = 10;
    localparam int OUT_MAX    = 2047;
    localparam int OUT_MIN    = -2048;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_SPEED_XY = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_XZ = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_XW = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_YZ = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_W_DIST   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CAM_DIST = 3'd5;

    // One vertex with the angles it is rotated by
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] w;
        logic [ANG_W-1:0]          ang_xy;
        logic [ANG_W-1:0]          ang_xz;
        logic [ANG_W-1:0]          ang_xw;
        logic [ANG_W-1:0]          ang_yz;
    } t_job;

    // Projection distances held in the register file
    typedef struct packed {
        logic [15:0] w_dist;
        logic [15:0] cam_dist;
    } t_proj_cfg;

    // Quarter-wave polynomial sine in Q1.14 for a 16-bit angle
    function automatic logic signed [SIN_W-1:0] poly_sine(input logic [ANG_W-1:0] ang);
        logic [1:0] quad;
        longint     r;
        longint     z;
        longint     z2;
        longint     t;
        quad = ang[15:14];
        r    = longint'(ang[13:0]);
        z    = quad[0] ? (longint'(QUARTER) - r) : r;
        z2   = (z * z) >>> 14;
        t    = 10512 - ((1160 * z2) >>> 14);
        t    = 25736 - ((z2 * t) >>> 14);
        t    = (z * t) >>> 14;
        if (quad[1]) begin
            t = -t;
        end
        return SIN_W'(t);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vrp_ifs.sv -----
// Handshake channels of the block: vertex input, screen result, register writes.
// Depends on vrp_pkg for field widths.
`default_nettype none

interface vrp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 frame_start;
    logic signed [vrp_pkg::COORD_W-1:0]   coord_x;
    logic signed [vrp_pkg::COORD_W-1:0]   coord_y;
    logic signed [vrp_pkg::COORD_W-1:0]   coord_z;
    logic signed [vrp_pkg::COORD_W-1:0]   coord_w;

    modport source (output valid, frame_start, coord_x, coord_y, coord_z, coord_w,
                    input ready);
    modport sink   (input valid, frame_start, coord_x, coord_y, coord_z, coord_w,
                    output ready);
endinterface

interface vrp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [vrp_pkg::OUT_W-1:0]   screen_x;
    logic signed [vrp_pkg::OUT_W-1:0]   screen_y;
    logic                               inside_margin;

    modport source (output valid, screen_x, screen_y, inside_margin, input ready);
    modport sink   (input valid, screen_x, screen_y, inside_margin, output ready);
endinterface

interface vrp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [vrp_pkg::REG_IDX_W-1:0]      index;
    logic [15:0]                        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/vertex_rotate_project_4d.sv -----
// Top level of the 4D vertex rotate/project block: front end, job queue, engine.
// Depends on vrp_pkg, vrp_ifs, vrp_front, vrp_fifo and vrp_back.
//
//   port    dir  payload                                        handshake
//   i_in    in   frame_start, coord_x/y/z/w (Q3.12)            valid/ready
//   o_out   out  screen_x, screen_y, inside_margin             valid/ready
//   i_cfg   in   index (3 b), data (16 b)                      valid/ready
//
// Most of an item's time in the engine goes to the two 28-step bit-serial
// divisions (4D and 3D scale); the four plane rotations come before them.
// Reset is synchronous and active low; no clearing pass is needed.
// The input takes up to two items ahead while the engine works; the result
// register holds one finished item while the engine starts the next.
`default_nettype none

module vertex_rotate_project_4d #(
    parameter int SCREEN_W         = 128,
    parameter int SCREEN_H         = 64,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    vrp_in_if.sink      i_in,
    vrp_out_if.source   o_out,
    vrp_cfg_if.sink     i_cfg
);

    logic               w_push, w_pop, w_full, w_empty;
    vrp_pkg::t_job      w_job_in, w_job_out;
    vrp_pkg::t_proj_cfg w_proj;

    vrp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job_in),
        .o_proj  (w_proj)
    );

    vrp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_job   (w_job_out)
    );

    vrp_back #(
        .SCREEN_W         (SCREEN_W),
        .SCREEN_H         (SCREEN_H),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_job_out),
        .i_proj  (w_proj),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/vrp_front.sv -----
// Front end: register file, plane angle update and job hand-off to the queue.
// Depends on vrp_pkg and vrp_ifs.
`default_nettype none

module vrp_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    vrp_in_if.sink              i_in,
    vrp_cfg_if.sink             i_cfg,
    input  wire                 i_full,
    output logic                o_push,
    output vrp_pkg::t_job       o_job,
    output vrp_pkg::t_proj_cfg  o_proj
);

    logic [15:0] r_speed_xy, r_speed_xz, r_speed_xw, r_speed_yz;
    logic [15:0] r_w_dist, r_cam_dist;
    logic [15:0] r_ang_xy, r_ang_xz, r_ang_xw, r_ang_yz;
    logic [15:0] n_ang_xy, n_ang_xz, n_ang_xw, n_ang_yz;
    logic        w_accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_full;
    assign w_accept    = i_in.valid && !i_full;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_xy <= 16'd180;
            r_speed_xz <= 16'd120;
            r_speed_xw <= 16'd90;
            r_speed_yz <= 16'd150;
            r_w_dist   <= 16'd12288;
            r_cam_dist <= 16'd16384;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                vrp_pkg::REG_SPEED_XY: r_speed_xy <= i_cfg.data;
                vrp_pkg::REG_SPEED_XZ: r_speed_xz <= i_cfg.data;
                vrp_pkg::REG_SPEED_XW: r_speed_xw <= i_cfg.data;
                vrp_pkg::REG_SPEED_YZ: r_speed_yz <= i_cfg.data;
                vrp_pkg::REG_W_DIST:   r_w_dist   <= i_cfg.data;
                vrp_pkg::REG_CAM_DIST: r_cam_dist <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Advance angles on frame start, wrapping
    always_comb begin
        n_ang_xy = r_ang_xy;
        n_ang_xz = r_ang_xz;
        n_ang_xw = r_ang_xw;
        n_ang_yz = r_ang_yz;
        if (i_in.frame_start) begin
            n_ang_xy = r_ang_xy + r_speed_xy;
            n_ang_xz = r_ang_xz + r_speed_xz;
            n_ang_xw = r_ang_xw + r_speed_xw;
            n_ang_yz = r_ang_yz + r_speed_yz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_xy <= '0;
            r_ang_xz <= '0;
            r_ang_xw <= '0;
            r_ang_yz <= '0;
        end else if (w_accept) begin
            r_ang_xy <= n_ang_xy;
            r_ang_xz <= n_ang_xz;
            r_ang_xw <= n_ang_xw;
            r_ang_yz <= n_ang_yz;
        end
    end

    // Build the job for the queue
    assign o_push       = w_accept;
    assign o_job.x      = i_in.coord_x;
    assign o_job.y      = i_in.coord_y;
    assign o_job.z      = i_in.coord_z;
    assign o_job.w      = i_in.coord_w;
    assign o_job.ang_xy = n_ang_xy;
    assign o_job.ang_xz = n_ang_xz;
    assign o_job.ang_xw = n_ang_xw;
    assign o_job.ang_yz = n_ang_yz;

    assign o_proj.w_dist   = r_w_dist;
    assign o_proj.cam_dist = r_cam_dist;

endmodule

`default_nettype wire

// ----- hw/rtl/vrp_fifo.sv -----
// Two-entry job queue between the front end and the transform engine.
// Depends on vrp_pkg for the job type.
`default_nettype none

module vrp_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  vrp_pkg::t_job  i_job,
    input  wire            i_pop,
    output logic           o_full,
    output logic           o_empty,
    output vrp_pkg::t_job  o_job
);

    vrp_pkg::t_job r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rd];

    // Store pushed job
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= !r_wr;
            end
            if (i_pop && !o_empty) begin
                r_rd <= !r_rd;
            end
            if ((i_push && !o_full) && !(i_pop && !o_empty)) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!(i_push && !o_full) && (i_pop && !o_empty)) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/vrp_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on vrp_pkg for operand widths.
`default_nettype none

module vrp_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [vrp_pkg::DVD_W-1:0]     i_dividend,
    input  wire [vrp_pkg::DVS_W-1:0]     i_divisor,
    output logic                         o_done,
    output logic [vrp_pkg::DVD_W-1:0]    o_quot
);

    localparam int CNT_W = $clog2(vrp_pkg::DVD_W + 1);

    logic [vrp_pkg::DVS_W-1:0] r_rem;
    logic [vrp_pkg::DVS_W-1:0] r_dvs;
    logic [vrp_pkg::DVD_W-1:0] r_quot;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [vrp_pkg::DVS_W:0]   w_trial;
    logic                      w_fit;

    // Shift in next dividend bit and try the subtract
    assign w_trial = {r_rem, r_quot[vrp_pkg::DVD_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(vrp_pkg::DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= w_fit ? vrp_pkg::DVS_W'(w_trial - {1'b0, r_dvs})
                            : vrp_pkg::DVS_W'(w_trial);
            r_quot <= {r_quot[vrp_pkg::DVD_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ----- hw/rtl/vrp_back.sv -----
// Transform engine: four plane rotations, 4D and 3D perspective, screen mapping.
// Depends on vrp_pkg, vrp_ifs and vrp_div; owns the result register.
`default_nettype none

module vrp_back #(
    parameter int SCREEN_W         = 128,
    parameter int SCREEN_H         = 64,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_empty,
    input  vrp_pkg::t_job       i_job,
    input  vrp_pkg::t_proj_cfg  i_proj,
    output logic                o_pop,
    vrp_out_if.source           o_out
);

    localparam int VW     = vrp_pkg::VW;
    localparam int ACC_W  = vrp_pkg::ACC_W;
    localparam int S4_W   = vrp_pkg::S4_W;
    localparam int OUT_W  = vrp_pkg::OUT_W;
    localparam int TAB_LG = $clog2(SINE_TABLE_DEPTH);
    localparam int TAB_SH = vrp_pkg::ANG_W - TAB_LG;
    localparam int HALF_W = SCREEN_W / 2;
    localparam int HALF_H = SCREEN_H / 2;
    localparam logic signed [OUT_W:0] X_LIM = (OUT_W+1)'(SCREEN_W - 1);
    localparam logic signed [OUT_W:0] Y_LIM = (OUT_W+1)'(SCREEN_H - 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_LUT  = 5'd1;
    localparam logic [4:0] S_M0   = 5'd2;
    localparam logic [4:0] S_M1   = 5'd3;
    localparam logic [4:0] S_M2   = 5'd4;
    localparam logic [4:0] S_M3   = 5'd5;
    localparam logic [4:0] S_WB   = 5'd6;
    localparam logic [4:0] S_D4   = 5'd7;
    localparam logic [4:0] S_DIV4 = 5'd8;
    localparam logic [4:0] S_P0   = 5'd9;
    localparam logic [4:0] S_P1   = 5'd10;
    localparam logic [4:0] S_P2   = 5'd11;
    localparam logic [4:0] S_P3   = 5'd12;
    localparam logic [4:0] S_D3   = 5'd13;
    localparam logic [4:0] S_DIV3 = 5'd14;
    localparam logic [4:0] S_Q0   = 5'd15;
    localparam logic [4:0] S_Q1   = 5'd16;
    localparam logic [4:0] S_Q2   = 5'd17;
    localparam logic [4:0] S_OUT  = 5'd18;

    logic [4:0]                        r_state;
    logic [1:0]                        r_rot;
    vrp_pkg::t_job                     r_job;
    logic signed [VW-1:0]              r_x, r_y, r_z, r_w, r_tmp;
    logic signed [vrp_pkg::SIN_W-1:0]  r_sin, r_cos;
    logic signed [ACC_W-1:0]           r_acc;
    logic signed [S4_W-1:0]            r_s4;
    logic [vrp_pkg::S3_W-1:0]          r_s3;
    logic                              r_neg;
    logic signed [OUT_W-1:0]           r_px, r_py;
    logic                              r_out_valid;
    logic signed [OUT_W-1:0]           r_out_x, r_out_y;
    logic                              r_out_in;

    logic signed [vrp_pkg::SIN_W-1:0]  w_tab [SINE_TABLE_DEPTH];
    logic [vrp_pkg::ANG_W-1:0]         w_ang, w_ang_c;
    logic signed [VW-1:0]              w_a, w_b;
    logic signed [VW-1:0]              w_mul_a;
    logic signed [S4_W-1:0]            w_mul_b;
    logic signed [VW+S4_W-1:0]         w_prod;
    logic signed [ACC_W-1:0]           w_prod_x;
    logic signed [VW:0]                w_wd, w_cd, w_den4, w_den4_mag, w_den3;
    logic                              w_div_start, w_div_done;
    logic [vrp_pkg::DVD_W-1:0]         w_dvd, w_quot;
    logic [vrp_pkg::DVS_W-1:0]         w_dvs;
    logic [S4_W-1:0]                   w_s4_mag;
    logic [vrp_pkg::S3_W-1:0]          w_s3;
    logic signed [ACC_W-1:0]           w_half, w_t, w_q;
    logic signed [OUT_W-1:0]           w_pix;
    logic                              w_out_free;
    logic                              w_inside;

    // Sine table, one entry per table step of the circle
    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_tab
        assign w_tab[gi] = vrp_pkg::poly_sine(vrp_pkg::ANG_W'(gi) << TAB_SH);
    end

    // Select plane operands for the current rotation
    always_comb begin
        unique case (r_rot)
            2'd0: begin w_ang = r_job.ang_xy; w_a = r_x; w_b = r_y; end
            2'd1: begin w_ang = r_job.ang_xz; w_a = r_x; w_b = r_z; end
            2'd2: begin w_ang = r_job.ang_xw; w_a = r_x; w_b = r_w; end
            2'd3: begin w_ang = r_job.ang_yz; w_a = r_y; w_b = r_z; end
            default: begin w_ang = r_job.ang_xy; w_a = r_x; w_b = r_y; end
        endcase
    end
    assign w_ang_c = w_ang + vrp_pkg::ANG_W'(vrp_pkg::QUARTER);

    // Shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_M0: begin w_mul_a = w_a; w_mul_b = S4_W'(r_cos); end
            S_M1: begin w_mul_a = w_b; w_mul_b = S4_W'(r_sin); end
            S_M2: begin w_mul_a = w_a; w_mul_b = S4_W'(r_sin); end
            S_M3: begin w_mul_a = w_b; w_mul_b = S4_W'(r_cos); end
            S_P0: begin w_mul_a = r_x; w_mul_b = r_s4; end
            S_P1: begin w_mul_a = r_y; w_mul_b = r_s4; end
            S_P2: begin w_mul_a = r_z; w_mul_b = r_s4; end
            S_Q0: begin w_mul_a = r_x; w_mul_b = $signed({4'b0, r_s3}); end
            S_Q1: begin w_mul_a = r_y; w_mul_b = $signed({4'b0, r_s3}); end
            default: ;
        endcase
    end
    assign w_prod   = w_mul_a * w_mul_b;
    assign w_prod_x = ACC_W'(w_prod);

    // Perspective denominators
    assign w_wd       = $signed({{(VW+1-16){1'b0}}, i_proj.w_dist});
    assign w_cd       = $signed({{(VW+1-16){1'b0}}, i_proj.cam_dist});
    assign w_den4     = w_wd - (VW+1)'(r_w);
    assign w_den4_mag = w_den4[VW] ? -w_den4 : w_den4;
    assign w_den3     = ((w_cd + (VW+1)'(r_z)) < (VW+1)'(vrp_pkg::DEN_FLOOR))
                      ? (VW+1)'(vrp_pkg::DEN_FLOOR) : (w_cd + (VW+1)'(r_z));

    assign w_div_start = ((r_state == S_D4) && (w_den4 != '0)) || (r_state == S_D3);
    assign w_dvd       = (r_state == S_D4) ? {i_proj.w_dist, 12'b0}
                                           : {i_proj.cam_dist, 12'b0};
    assign w_dvs       = (r_state == S_D4) ? vrp_pkg::DVS_W'(unsigned'(w_den4_mag))
                                           : vrp_pkg::DVS_W'(unsigned'(w_den3));

    vrp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Saturate and clamp the scales
    assign w_s4_mag = (w_quot > vrp_pkg::DVD_W'(vrp_pkg::S4_LIMIT))
                    ? S4_W'(vrp_pkg::S4_LIMIT) : S4_W'(w_quot);
    always_comb begin
        if (w_quot < vrp_pkg::DVD_W'(vrp_pkg::SCALE_MIN)) begin
            w_s3 = vrp_pkg::S3_W'(vrp_pkg::SCALE_MIN);
        end else if (w_quot > vrp_pkg::DVD_W'(vrp_pkg::SCALE_MAX)) begin
            w_s3 = vrp_pkg::S3_W'(vrp_pkg::SCALE_MAX);
        end else begin
            w_s3 = vrp_pkg::S3_W'(w_quot);
        end
    end

    // Screen mapping: center plus gain, truncate toward zero, saturate
    assign w_half = (r_state == S_Q1) ? ACC_W'(HALF_W) : ACC_W'(HALF_H);
    assign w_t    = (w_half <<< 24) + r_acc * ACC_W'(vrp_pkg::PIXEL_GAIN);
    assign w_q    = w_t[ACC_W-1] ? ((w_t + ACC_W'((1 << 24) - 1)) >>> 24) : (w_t >>> 24);
    always_comb begin
        if (w_q > ACC_W'(vrp_pkg::OUT_MAX)) begin
            w_pix = OUT_W'(vrp_pkg::OUT_MAX);
        end else if (w_q < ACC_W'(vrp_pkg::OUT_MIN)) begin
            w_pix = OUT_W'(vrp_pkg::OUT_MIN);
        end else begin
            w_pix = OUT_W'(w_q);
        end
    end

    assign w_inside = ((OUT_W+1)'(r_px) >= (OUT_W+1)'(1)) && ((OUT_W+1)'(r_px) < X_LIM)
                   && ((OUT_W+1)'(r_py) >= (OUT_W+1)'(1)) && ((OUT_W+1)'(r_py) < Y_LIM);

    assign w_out_free = !r_out_valid || o_out.ready;
    assign o_pop      = (r_state == S_IDLE) && !i_empty;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rot   <= 2'd0;
        end else begin
            unique case (r_state)
                S_IDLE: if (!i_empty) begin
                    r_state <= S_LUT;
                    r_rot   <= 2'd0;
                end
                S_LUT:  r_state <= S_M0;
                S_M0:   r_state <= S_M1;
                S_M1:   r_state <= S_M2;
                S_M2:   r_state <= S_M3;
                S_M3:   r_state <= S_WB;
                S_WB: begin
                    if (r_rot == 2'd3) begin
                        r_state <= S_D4;
                    end else begin
                        r_rot   <= r_rot + 2'd1;
                        r_state <= S_LUT;
                    end
                end
                S_D4:   r_state <= (w_den4 == '0) ? S_P0 : S_DIV4;
                S_DIV4: if (w_div_done) r_state <= S_P0;
                S_P0:   r_state <= S_P1;
                S_P1:   r_state <= S_P2;
                S_P2:   r_state <= S_P3;
                S_P3:   r_state <= S_D3;
                S_D3:   r_state <= S_DIV3;
                S_DIV3: if (w_div_done) r_state <= S_Q0;
                S_Q0:   r_state <= S_Q1;
                S_Q1:   r_state <= S_Q2;
                S_Q2:   r_state <= S_OUT;
                S_OUT:  if (w_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_job <= i_job;
                r_x   <= VW'(i_job.x);
                r_y   <= VW'(i_job.y);
                r_z   <= VW'(i_job.z);
                r_w   <= VW'(i_job.w);
            end
            S_LUT: begin
                r_sin <= w_tab[w_ang[vrp_pkg::ANG_W-1 -: TAB_LG]];
                r_cos <= w_tab[w_ang_c[vrp_pkg::ANG_W-1 -: TAB_LG]];
            end
            S_M0: r_acc <= w_prod_x + ACC_W'(vrp_pkg::ROT_RND);
            S_M1: r_acc <= r_acc - w_prod_x;
            S_M2: begin
                r_tmp <= VW'(r_acc >>> 14);
                r_acc <= w_prod_x + ACC_W'(vrp_pkg::ROT_RND);
            end
            S_M3: r_acc <= r_acc + w_prod_x;
            S_WB: begin
                unique case (r_rot)
                    2'd0: begin r_x <= r_tmp; r_y <= VW'(r_acc >>> 14); end
                    2'd1: begin r_x <= r_tmp; r_z <= VW'(r_acc >>> 14); end
                    2'd2: begin r_x <= r_tmp; r_w <= VW'(r_acc >>> 14); end
                    2'd3: begin r_y <= r_tmp; r_z <= VW'(r_acc >>> 14); end
                    default: ;
                endcase
            end
            S_D4: begin
                r_neg <= w_den4[VW];
                if (w_den4 == '0) begin
                    r_s4 <= (i_proj.w_dist == 16'd0) ? '0 : S4_W'(vrp_pkg::S4_LIMIT);
                end
            end
            S_DIV4: if (w_div_done) begin
                r_s4 <= r_neg ? -$signed(w_s4_mag) : $signed(w_s4_mag);
            end
            S_P0: r_acc <= w_prod_x + ACC_W'(vrp_pkg::PRJ_RND);
            S_P1: begin
                r_x   <= VW'(r_acc >>> 12);
                r_acc <= w_prod_x + ACC_W'(vrp_pkg::PRJ_RND);
            end
            S_P2: begin
                r_y   <= VW'(r_acc >>> 12);
                r_acc <= w_prod_x + ACC_W'(vrp_pkg::PRJ_RND);
            end
            S_P3: r_z <= VW'(r_acc >>> 12);
            S_DIV3: if (w_div_done) r_s3 <= w_s3;
            S_Q0: r_acc <= w_prod_x;
            S_Q1: begin
                r_px  <= w_pix;
                r_acc <= w_prod_x;
            end
            S_Q2: r_py <= w_pix;
            default: ;
        endcase
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_x  <= r_px;
            r_out_y  <= r_py;
            r_out_in <= w_inside;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.screen_x      = r_out_x;
    assign o_out.screen_y      = r_out_y;
    assign o_out.inside_margin = r_out_in;

    // Divider finishes only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV4 || r_state == S_DIV3))
        else $error("divider done outside a wait state");

    // 4D scale stays within its saturation limit
    a_s4_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P0) |-> (r_s4 <= vrp_pkg::S4_LIMIT && r_s4 >= -vrp_pkg::S4_LIMIT))
        else $error("4D scale out of range");

    // 3D scale is clamped before screen mapping
    a_s3_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q0) |-> (r_s3 >= vrp_pkg::SCALE_MIN && r_s3 <= vrp_pkg::SCALE_MAX))
        else $error("3D scale out of range");

    // Last plane rotation moves on to the 4D projection
    a_rot_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB && r_rot == 2'd3) |=> (r_state == S_D4))
        else $error("rotation sequence did not finish");

endmodule

`default_nettype wire
